@@ rtl/tbdcc_pkg.sv @@
// Package for the two-button debounce and chord counter.
// Holds timer widths, action codes, register indexes and the config struct.
// No dependencies.
package tbdcc_pkg;

   localparam int TIMER_BITS = 12;
   localparam int CFG_BITS   = 12;
   localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
   localparam int COUNT_BITS = 7;
   localparam int ACT_BITS   = 3;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(99);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   typedef enum logic [ACT_BITS-1:0] {
      ACT_NONE       = 3'd0,
      ACT_PRACTICE   = 3'd1,
      ACT_STANDALONE = 3'd2,
      ACT_UP         = 3'd3,
      ACT_DOWN       = 3'd4
   } action_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEBOUNCE_TICKS = 2'd0,
      CSR_COMBO_TICKS    = 2'd1,
      CSR_AP_MODE        = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_ticks;
      logic [CFG_BITS-1:0] combo_ticks;
      logic                ap_mode;
   } cfg_type;

endpackage

@@ rtl/tbdcc_if.sv @@
// Channel interfaces: button tick request, result response, register write.
// Depends on tbdcc_pkg.
interface tbdcc_req_if;
   logic valid;
   logic ready;
   logic raw_up;
   logic raw_down;
   modport source (output valid, raw_up, raw_down, input ready);
   modport sink   (input valid, raw_up, raw_down, output ready);
endinterface

interface tbdcc_rsp_if;
   import tbdcc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ACT_BITS-1:0]   action;
   logic [COUNT_BITS-1:0] count_value;
   logic                  up_stable;
   logic                  down_stable;
   modport source (output valid, action, count_value, up_stable, down_stable, input ready);
   modport sink   (input valid, action, count_value, up_stable, down_stable, output ready);
endinterface

interface tbdcc_csr_if;
   import tbdcc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CFG_BITS-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/two_button_debounce_chord_counter.sv @@
// Two-button debouncer with chord detection and a 0..99 race count that wraps between 99 and 1.
// One request transfer is one millisecond tick with the raw up/down levels; every tick
// gives exactly one response. A tick is processed in the cycle it is taken and its result
// sits in the response register the next cycle, so one tick per clock is sustained: the
// request side is ready whenever the response register is empty or being taken. Register
// writes (0 debounce_ticks, 1 combo_ticks, 2 ap_mode) are always taken.
// Depends on tbdcc_pkg, tbdcc_if, tbdcc_debounce, tbdcc_chord.
module two_button_debounce_chord_counter (
   input  logic        clock,
   input  logic        reset,
   tbdcc_req_if.sink   req_bus,
   tbdcc_rsp_if.source rsp_bus,
   tbdcc_csr_if.sink   csr_bus
);
   import tbdcc_pkg::*;

   cfg_type               cfg_ff;
   logic                  step;
   logic                  up_in, dn_in;
   action_type            action;
   logic [COUNT_BITS-1:0] count_in;

   logic                  rsp_valid_ff;
   action_type            action_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  up_ff, dn_ff;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign step          = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= CFG_BITS'(50);
         cfg_ff.combo_ticks    <= CFG_BITS'(300);
         cfg_ff.ap_mode        <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_DEBOUNCE_TICKS: cfg_ff.debounce_ticks <= csr_bus.data;
            CSR_COMBO_TICKS:    cfg_ff.combo_ticks    <= csr_bus.data;
            CSR_AP_MODE:        cfg_ff.ap_mode        <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   tbdcc_debounce u_up (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .raw            (req_bus.raw_up),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .stable_in      (up_in)
   );

   tbdcc_debounce u_dn (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .raw            (req_bus.raw_down),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .stable_in      (dn_in)
   );

   tbdcc_chord u_chord (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .up       (up_in),
      .dn       (dn_in),
      .cfg      (cfg_ff),
      .action   (action),
      .count_in (count_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         rsp_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         action_ff <= action;
         count_ff  <= count_in;
         up_ff     <= up_in;
         dn_ff     <= dn_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.action      = action_ff;
   assign rsp_bus.count_value = count_ff;
   assign rsp_bus.up_stable   = up_ff;
   assign rsp_bus.down_stable = dn_ff;

   a_transfer_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("accepted tick produced no response");

   a_rsp_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> count_ff <= COUNT_MAX)
      else $error("response count out of range");

   a_up_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && action_ff == ACT_UP) |-> count_ff != '0)
      else $error("count up left count at zero");

   a_ap_no_singles: assert property (@(posedge clock) disable iff (reset)
      (step && cfg_ff.ap_mode) |-> (action != ACT_UP && action != ACT_DOWN))
      else $error("single-button action in access-point mode");

endmodule

@@ rtl/tbdcc_debounce.sv @@
// One-button debouncer: raw level history, saturating stable age, debounced level.
// Depends on tbdcc_pkg.
module tbdcc_debounce (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           raw,
   input  logic [tbdcc_pkg::CFG_BITS-1:0] debounce_ticks,
   output logic                           stable_in
);
   import tbdcc_pkg::*;

   logic                  last_raw_ff;
   logic                  stable_ff;
   logic [TIMER_BITS-1:0] age_ff;
   logic [TIMER_BITS-1:0] age_in;

   always_comb begin
      stable_in = stable_ff;
      if (raw != last_raw_ff) begin
         age_in = '0;
      end else begin
         age_in = (age_ff == '1) ? age_ff : age_ff + TIMER_BITS'(1);
         if (raw != stable_ff && CMP_BITS'(age_in) >= CMP_BITS'(debounce_ticks)) begin
            stable_in = raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= 1'b0;
         stable_ff   <= 1'b0;
         age_ff      <= '0;
      end else if (step) begin
         last_raw_ff <= raw;
         stable_ff   <= stable_in;
         age_ff      <= age_in;
      end
   end

endmodule

@@ rtl/tbdcc_chord.sv @@
// Press window, chord detection and the 0..99 race count, which wraps between 99 and 1.
// Depends on tbdcc_pkg.
module tbdcc_chord (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             up,
   input  logic                             dn,
   input  tbdcc_pkg::cfg_type               cfg,
   output tbdcc_pkg::action_type            action,
   output logic [tbdcc_pkg::COUNT_BITS-1:0] count_in
);
   import tbdcc_pkg::*;

   logic                  pending_ff, pending_in;
   logic                  hold_ff, hold_in;
   logic                  seen_up_ff, seen_up_in;
   logic                  seen_dn_ff, seen_dn_in;
   logic [TIMER_BITS-1:0] window_ff, window_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  chord, released, expired;

   always_comb begin
      pending_in = pending_ff;
      hold_in    = hold_ff;
      seen_up_in = seen_up_ff;
      seen_dn_in = seen_dn_ff;
      window_in  = window_ff;
      count_in   = count_ff;
      action     = ACT_NONE;
      released   = !up && !dn;
      chord      = 1'b0;
      expired    = 1'b0;
      if (hold_ff) begin
         if (released) begin
            hold_in = 1'b0;
         end
      end else if (pending_ff || !released) begin
         if (!pending_ff) begin
            pending_in = 1'b1;
            window_in  = '0;
            seen_up_in = up;
            seen_dn_in = dn;
         end else begin
            window_in  = (window_ff == '1) ? window_ff : window_ff + TIMER_BITS'(1);
            seen_up_in = seen_up_ff || up;
            seen_dn_in = seen_dn_ff || dn;
         end
         chord   = seen_up_in && seen_dn_in;
         expired = CMP_BITS'(window_in) >= CMP_BITS'(cfg.combo_ticks);
         if (chord || released || expired) begin
            pending_in = 1'b0;
            hold_in    = 1'b1;
            if (chord) begin
               action = cfg.ap_mode ? ACT_STANDALONE : ACT_PRACTICE;
            end else if (cfg.ap_mode) begin
               action = ACT_NONE;
            end else if (seen_up_in) begin
               count_in = (count_ff >= COUNT_MAX) ? COUNT_ONE : count_ff + COUNT_ONE;
               action   = ACT_UP;
            end else if (count_ff != '0) begin
               count_in = (count_ff == COUNT_ONE) ? COUNT_MAX : count_ff - COUNT_ONE;
               action   = ACT_DOWN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         hold_ff    <= 1'b0;
         seen_up_ff <= 1'b0;
         seen_dn_ff <= 1'b0;
         window_ff  <= '0;
         count_ff   <= '0;
      end else if (step) begin
         pending_ff <= pending_in;
         hold_ff    <= hold_in;
         seen_up_ff <= seen_up_in;
         seen_dn_ff <= seen_dn_in;
         window_ff  <= window_in;
         count_ff   <= count_in;
      end
   end

   a_hold_pending_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(hold_ff && pending_ff))
      else $error("hold and pending window both set");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("race count out of range");

   a_action_holds: assert property (@(posedge clock) disable iff (reset)
      (step && action != ACT_NONE) |=> hold_ff)
      else $error("decision did not enter hold");

endmodule
